/* hdl/mpc_pkg.sv */
// ----------------------------------------------------------------------------
// mpc_pkg
// shared types, constants and the powers-of-two table for the correlation core
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int TAB_BITS = $clog2(EXP_TABLE_ENTRIES);

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [22:0] POLY_CAP  = 23'h40_0000;
  localparam logic [15:0] POLY_ONE  = 16'hFFFF;

  localparam logic [1:0] CODE_EXP   = 2'd0;
  localparam logic [1:0] CODE_M32   = 2'd1;
  localparam logic [1:0] CODE_M52   = 2'd2;
  localparam logic [1:0] CODE_GAUSS = 2'd3;

  typedef logic [31:0] pow2_tab_t [0:EXP_TABLE_ENTRIES];

  typedef struct packed {
    logic [31:0] diff;
    logic [31:0] theta;
    logic [1:0]  code;
    logic        last;
    logic        inactive;
  } mpc_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_DIST, ST_EXPY, ST_TAB, ST_INTERP,
    ST_SHIFT, ST_DIV3, ST_POLY, ST_PROD
  } mpc_state_t;

  // 2^(-i/N) from a truncated series in Q32, rounded to Q1.31
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t   tab;
    logic [127:0] t;
    logic [127:0] sum;
    logic [127:0] term;
    logic [127:0] v;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      t    = (128'(i) * 128'(LN2_Q32)) / 128'(EXP_TABLE_ENTRIES);
      sum  = 128'(1) << 32;
      term = 128'(1) << 32;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * t) >> 32) / 128'(k);
        if ((k % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 128'(0);
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 128'(1)) >> 1;
      if (v > 128'(ONE_Q31)) begin
        v = 128'(ONE_Q31);
      end
      tab[i] = v[31:0];
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

/* hdl/mpc_front.sv */
// ----------------------------------------------------------------------------
// mpc_front
// takes input transfers, forms the coordinate distance and classifies the term
// ----------------------------------------------------------------------------
module mpc_front (
  input  logic               [31:0] query_coord,
  input  logic               [31:0] design_coord,
  input  logic               [31:0] theta_weight,
  input  logic               [1:0]  smoothness,
  input  logic                      last_term,
  output mpc_pkg::mpc_item_t        item
);
  import mpc_pkg::*;

  logic signed [32:0] sd;

  always_comb begin
    sd = {query_coord[31], query_coord} - {design_coord[31], design_coord};
    item.diff     = sd[32] ? 32'(-sd) : sd[31:0];
    item.theta    = theta_weight;
    item.code     = smoothness;
    item.last     = last_term;
    item.inactive = (theta_weight == '0);
  end

endmodule

/* hdl/mpc_queue.sv */
// ----------------------------------------------------------------------------
// mpc_queue
// two-entry queue between the front and the factor sequencer
// ----------------------------------------------------------------------------
module mpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mpc_pkg::mpc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output mpc_pkg::mpc_item_t  pop_item,
  output logic                empty
);
  import mpc_pkg::*;

  mpc_item_t  mem_r [0:1];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    full      = (count_r == 2'd2);
    empty     = (count_r == 2'd0);
    pop_item  = mem_r[rptr_r];
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

/* hdl/mpc_back.sv */
// ----------------------------------------------------------------------------
// mpc_back
// factor sequencer: one shared multiplier stepped through the term's math
// ----------------------------------------------------------------------------
module mpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         threshold,
  input  logic                q_empty,
  input  mpc_pkg::mpc_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_data
);
  import mpc_pkg::*;

  mpc_state_t state_r, state_nxt;

  mpc_item_t   item_r;
  logic [31:0] x_r, dist_r, a_r, ad_r, v_r, e_r, f_r;
  logic        down_r;
  logic [62:0] y_r;
  logic [22:0] dp_r;
  logic [28:0] sq_r, poly_r;
  logic [31:0] prod_r, prod_nxt;
  logic        oval_r, oval_nxt;
  logic [31:0] odata_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] sat_p;
  logic [TAB_BITS:0] idx;
  logic [29:0] frac_r;
  logic [31:0] tab_a, tab_b, step;
  logic [16:0] n;
  logic [30:0] q3;
  logic [47:0] f_full;
  logic        emit;

  always_comb begin
    unique case (state_r)
      ST_SQ:     begin mul_a = item_r.diff;  mul_b = item_r.diff; end
      ST_DIST:   begin mul_a = item_r.theta; mul_b = x_r;         end
      ST_EXPY:   begin mul_a = dist_r;       mul_b = LOG2E_Q30;   end
      ST_INTERP: begin mul_a = ad_r;         mul_b = 32'(frac_r); end
      ST_SHIFT:  begin mul_a = 32'(dp_r);    mul_b = 32'(dp_r);   end
      ST_DIV3:   begin mul_a = 32'(sq_r);    mul_b = RECIP3;      end
      ST_POLY:   begin mul_a = e_r;          mul_b = 32'(poly_r); end
      ST_PROD:   begin mul_a = prod_r;       mul_b = f_r;         end
      default:   begin mul_a = '0;           mul_b = '0;          end
    endcase
    mul_p  = 64'(mul_a) * 64'(mul_b);
    sat_p  = (mul_p[63:48] != '0) ? '1 : mul_p[47:16];
    idx    = {1'b0, y_r[45 -: TAB_BITS]};
    tab_a  = POW2_TAB[idx];
    tab_b  = POW2_TAB[idx + 1'b1];
    step   = mul_p[61:30];
    n      = y_r[62:46];
    q3     = mul_p[63:33];
    f_full = mul_p[63:16];
    prod_nxt = mul_p[62:31];
    emit   = (state_r == ST_PROD) && item_r.last && !(oval_r && !out_ready);
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.inactive) begin
            state_nxt = ST_PROD;
          end else if (q_item.code == CODE_GAUSS) begin
            state_nxt = ST_SQ;
          end else begin
            state_nxt = ST_DIST;
          end
        end
      end
      ST_SQ:     state_nxt = ST_DIST;
      ST_DIST:   state_nxt = ST_EXPY;
      ST_EXPY:   state_nxt = ST_TAB;
      ST_TAB:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = ST_DIV3;
      ST_DIV3:   state_nxt = ST_POLY;
      ST_POLY:   state_nxt = ST_PROD;
      ST_PROD: begin
        if (!(item_r.last && oval_r && !out_ready)) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
    oval_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : oval_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
      prod_r  <= ONE_Q31;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      if (state_r == ST_PROD && state_nxt == ST_IDLE) begin
        prod_r <= item_r.last ? ONE_Q31 : prod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      x_r    <= q_item.diff;
      f_r    <= ONE_Q31;
    end
    if (emit) begin
      odata_r <= prod_nxt;
    end
    unique case (state_r)
      ST_SQ:   x_r    <= sat_p;
      ST_DIST: dist_r <= sat_p;
      ST_EXPY: y_r    <= mul_p[62:0];
      ST_TAB: begin
        a_r    <= tab_a;
        down_r <= (tab_a >= tab_b);
        ad_r   <= (tab_a >= tab_b) ? tab_a - tab_b : tab_b - tab_a;
        frac_r <= y_r[45-TAB_BITS -: 30];
        dp_r   <= (dist_r > 32'(POLY_CAP)) ? POLY_CAP : dist_r[22:0];
      end
      ST_INTERP: v_r <= down_r ? a_r - step : a_r + step;
      ST_SHIFT: begin
        sq_r <= mul_p[44:16];
        if (dist_r < 32'(threshold)) begin
          e_r <= ONE_Q31;
        end else if (n[16:5] != '0) begin
          e_r <= '0;
        end else begin
          e_r <= v_r >> n[4:0];
        end
      end
      ST_DIV3: begin
        poly_r <= 29'(POLY_ONE) + 29'd1
                  + ((item_r.code == CODE_M32 || item_r.code == CODE_M52) ? 29'(dp_r) : '0)
                  + ((item_r.code == CODE_M52) ? 29'(q3) : '0);
      end
      ST_POLY: f_r <= (f_full > 48'(ONE_Q31)) ? ONE_Q31 : f_full[31:0];
      default: ;
    endcase
  end

  assign out_valid = oval_r;
  assign out_data  = odata_r;

endmodule

/* hdl/matern_product_correlation_core.sv */
// ----------------------------------------------------------------------------
// matern_product_correlation_core
// product of per-dimension Matern-family correlation factors
// ----------------------------------------------------------------------------
// Each in_ transfer is one dimension term: query and design coordinates,
// weight (tdata) and smoothness code (tuser); tlast marks the last term of a
// point pair. On that term one out_ transfer carries the Q1.31 product, and
// the running product goes back to 1.0.
// An accepted term enters a two-entry queue; a sequencer around one shared
// 32x32 multiplier steps one term at a time through its states (a Gaussian
// term adds ST_SQ first; a zero-weight term goes straight to ST_PROD), which
// sets the throughput. With the sequencer idle, the last term is popped, run
// through its states to ST_PROD, and out tvalid rises from a register.
// in_tready drops only while the queue is full. The result sits in an output
// register; while the receiver stalls, the sequencer waits on the next last
// term but keeps working earlier terms.
// After reset the product is 1.0 and the threshold register reads 1. The
// threshold is written over the cfg_ port at byte addresses 0 to 3.
module matern_product_correlation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // query_coord, design_coord, theta_weight
  input  logic [1:0]  in_tuser,   // smoothness
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // correlation
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mpc_pkg::*;

  logic [15:0] thr_r;
  mpc_item_t   f_item, q_item;
  logic        q_full, q_empty, q_pop, push;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      thr_r <= cfg_pwdata[15:0];
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  mpc_front u_front (
    .query_coord  (in_tdata[31:0]),
    .design_coord (in_tdata[63:32]),
    .theta_weight (in_tdata[95:64]),
    .smoothness   (in_tuser),
    .last_term    (in_tlast),
    .item         (f_item)
  );

  mpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  mpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
